>>> hdl/bda_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bda_pkg: shared types and constants of the business day date adder
// Field widths, calendar constants, probe and converter records, FSM states.
// ----------------------------------------------------------------------------
package bda_pkg;

    // table geometry
    localparam int HOLIDAY_SLOTS = 32;

    // field widths
    localparam int YEAR_W   = 14;
    localparam int MONTH_W  = 4;
    localparam int DAY_W    = 5;
    localparam int COUNT_W  = 10;
    localparam int SLOT_W   = 5;
    localparam int SERIAL_W = 23;
    localparam int HCOUNT_W = 6;
    localparam int WD_W     = 3;

    // configuration port
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam logic [APB_ADDR_W-3:0] REG_HOLIDAY_COUNT = 1'b0;

    // item kinds
    localparam logic FUNC_LOAD  = 1'b0;
    localparam logic FUNC_QUERY = 1'b1;

    // weekday codes, Sunday first
    localparam logic [WD_W-1:0] WD_SUN = 3'd0;
    localparam logic [WD_W-1:0] WD_SAT = 3'd6;

    // calendar constants
    localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
    localparam logic [YEAR_W-1:0]  ERA_YEARS  = 14'd400;
    localparam logic [26:0]        ERA_RECIP  = 27'd10485;   // floor(2^22 / 400)
    localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
    localparam logic [SERIAL_W-1:0] ERA_DAYS  = 23'd146097;
    localparam logic [23:0]        EPOCH_BIAS = 24'd865566;  // 719468 + one era + 1
    localparam logic [23:0]        WD_BIAS    = 24'd2;

    // day of year of the first of each month in a March-based year
    localparam logic [8:0] DOY_BASE [16] = '{
        9'd275, 9'd306, 9'd337, 9'd0,   9'd31,  9'd61,  9'd92,  9'd122,
        9'd153, 9'd184, 9'd214, 9'd245, 9'd275, 9'd306, 9'd337, 9'd367
    };

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_RUN,
        ST_PUSH
    } t_state;

    // candidate day travelling along the holiday cells
    typedef struct packed {
        logic                       valid;
        logic                       first;
        logic                       weekend;
        logic                       hit;
        logic signed [SERIAL_W-1:0] serial;
    } t_probe;

    // converter output
    typedef struct packed {
        logic                       valid;
        logic signed [SERIAL_W-1:0] serial;
        logic [WD_W-1:0]            wd;
    } t_conv_res;

endpackage
`default_nettype wire

>>> hdl/bda_if.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bda_if: request and response channels
// Valid/ready channels carrying date items in and business day results out.
// ----------------------------------------------------------------------------
interface bda_req_if;
    logic                         valid;
    logic                         ready;
    logic                         func;
    logic [bda_pkg::YEAR_W-1:0]   year;
    logic [bda_pkg::MONTH_W-1:0]  month;
    logic [bda_pkg::DAY_W-1:0]    day;
    logic [bda_pkg::COUNT_W-1:0]  count;
    logic [bda_pkg::SLOT_W-1:0]   slot;

    modport source (output valid, func, year, month, day, count, slot, input ready);
    modport sink   (input valid, func, year, month, day, count, slot, output ready);
endinterface

interface bda_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [bda_pkg::SERIAL_W-1:0] result_serial;
    logic                                start_is_business;

    modport source (output valid, result_serial, start_is_business, input ready);
    modport sink   (input valid, result_serial, start_is_business, output ready);
endinterface
`default_nettype wire

>>> hdl/bda_conv.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bda_conv: civil date to day serial converter
// Six-stage pipeline: era, year of era, day of era, serial and weekday.
// ----------------------------------------------------------------------------
module bda_conv (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_valid,
    input  wire logic [bda_pkg::YEAR_W-1:0]    i_year,
    input  wire logic [bda_pkg::MONTH_W-1:0]   i_month,
    input  wire logic [bda_pkg::DAY_W-1:0]     i_day,
    output bda_pkg::t_conv_res                 o_res
);

    // octal digit fold: 8 == 1 mod 7
    function automatic logic [bda_pkg::WD_W-1:0] mod7(input logic [23:0] v);
        logic [5:0] sum;
        logic [3:0] fold;
        sum = '0;
        for (int k = 0; k < 8; k++) begin
            sum = sum + 6'(v[3*k +: 3]);
        end
        fold = 4'(sum[5:3]) + 4'(sum[2:0]);
        if (fold >= 4'd14) begin
            fold = fold - 4'd14;
        end else if (fold >= 4'd7) begin
            fold = fold - 4'd7;
        end
        return fold[2:0];
    endfunction

    logic [5:0] r_vld;

    // stage 1: saturate year, shift by one era, look up month start
    logic [bda_pkg::YEAR_W-1:0] w_ysat;
    logic                       w_early;
    logic [bda_pkg::YEAR_W-1:0] r_yp;
    logic [8:0]                 r_dd;
    // stage 2: era estimate
    logic [26:0]                w_prod;
    logic [4:0]                 r_era_e;
    logic [bda_pkg::YEAR_W-1:0] r_yp2;
    logic [8:0]                 r_dd2;
    // stage 3: correct era, year of era
    logic [bda_pkg::YEAR_W-1:0] w_rem;
    logic                       w_fix;
    logic [4:0]                 r_era;
    logic [8:0]                 r_yoe;
    logic [8:0]                 r_dd3;
    // stage 4: era days and day of era
    logic [13:0]                w_c100;
    logic [bda_pkg::SERIAL_W-1:0] r_era_term;
    logic [17:0]                r_doe;
    // stage 5: shifted serial
    logic [bda_pkg::SERIAL_W-1:0] r_v;
    // stage 6: serial and weekday
    logic [23:0]                w_vp;
    logic [23:0]                w_s;
    logic signed [bda_pkg::SERIAL_W-1:0] r_serial;
    logic [bda_pkg::WD_W-1:0]   r_wd;

    assign w_ysat  = (i_year > bda_pkg::YEAR_MAX) ? bda_pkg::YEAR_MAX : i_year;
    assign w_early = (i_month <= bda_pkg::MONTH_FEB);
    assign w_prod  = 27'(r_yp) * bda_pkg::ERA_RECIP;
    assign w_rem   = r_yp2 - bda_pkg::YEAR_W'(14'(r_era_e) * bda_pkg::ERA_YEARS);
    assign w_fix   = (w_rem >= bda_pkg::ERA_YEARS);
    assign w_c100  = 14'(r_yoe) * 14'd41;
    assign w_vp    = 24'(r_v) + bda_pkg::WD_BIAS;
    assign w_s     = 24'(r_v) - bda_pkg::EPOCH_BIAS;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[4:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_yp       <= w_ysat + bda_pkg::ERA_YEARS - bda_pkg::YEAR_W'(w_early);
        r_dd       <= bda_pkg::DOY_BASE[i_month] + 9'(i_day);

        r_era_e    <= w_prod[26:22];
        r_yp2      <= r_yp;
        r_dd2      <= r_dd;

        r_era      <= r_era_e + 5'(w_fix);
        r_yoe      <= w_fix ? 9'(w_rem - bda_pkg::ERA_YEARS) : 9'(w_rem);
        r_dd3      <= r_dd2;

        r_era_term <= 23'(r_era) * bda_pkg::ERA_DAYS;
        r_doe      <= 18'(r_yoe) * 18'd365 + 18'(r_yoe[8:2])
                      - 18'(w_c100[13:12]) + 18'(r_dd3);

        r_v        <= r_era_term + 23'(r_doe);

        r_serial   <= signed'(w_s[bda_pkg::SERIAL_W-1:0]);
        r_wd       <= mod7(w_vp);
    end

    assign o_res.valid  = r_vld[5];
    assign o_res.serial = r_serial;
    assign o_res.wd     = r_wd;

endmodule
`default_nettype wire

>>> hdl/bda_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// bda_cell: one holiday slot in the probe chain
// Holds one holiday serial and marks a passing candidate day that matches it.
// ----------------------------------------------------------------------------
module bda_cell (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    input  wire logic                                i_flush,
    input  wire logic                                i_en,
    input  wire logic                                i_we,
    input  wire logic signed [bda_pkg::SERIAL_W-1:0] i_wdata,
    input  wire bda_pkg::t_probe                     i_probe,
    output bda_pkg::t_probe                          o_probe
);

    logic signed [bda_pkg::SERIAL_W-1:0] r_entry;
    logic                                r_valid;
    bda_pkg::t_probe                     r_probe;
    bda_pkg::t_probe                     n_probe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_probe.valid && !i_flush;
        end
    end

    // mark the candidate when it matches this slot
    always_comb begin
        n_probe     = i_probe;
        n_probe.hit = i_probe.hit || (i_en && (r_entry == i_probe.serial));
    end

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_entry <= i_wdata;
        end
        r_probe <= n_probe;
    end

    always_comb begin
        o_probe       = r_probe;
        o_probe.valid = r_valid;
    end

endmodule
`default_nettype wire

>>> hdl/business_day_date_adder.sv
`default_nettype none
// ----------------------------------------------------------------------------
// business_day_date_adder: business day addition on civil dates
// Converts dates to day serials, keeps a holiday table and steps a start
// date forward by a number of business days.
// ----------------------------------------------------------------------------
//
//  channel   | dir | handshake              | carries
//  ----------+-----+------------------------+----------------------------------
//  i_req     | in  | valid / ready          | func, year, month, day, count, slot
//  o_rsp     | out | valid / ready          | result_serial, start_is_business
//  APB       | in  | psel, penable, pready  | holiday_count at byte address 0
//
//  Timing: a load passes through the six-stage converter and then the table
//  write before the next acceptance. A query converts its date, then streams
//  its candidate days into the holiday cell chain one per cycle, and each
//  passes all HOLIDAY_SLOTS cells before it is counted. One item is in work
//  at a time.
//  Reset: synchronous, active low; clears control, valid bits and the count.
//  Table entries are not cleared and must be loaded before a query uses them.
//  Stalls: a result waits in the output register while the next transaction
//  is accepted; a finished query holds in the push state until that register
//  frees up.
// ----------------------------------------------------------------------------
module business_day_date_adder (
    input  wire logic                                i_clk,
    input  wire logic                                i_rst_n,
    bda_req_if.sink                                  i_req,
    bda_rsp_if.source                                o_rsp,
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [bda_pkg::APB_ADDR_W-1:0]      paddr,
    input  wire logic [bda_pkg::APB_DATA_W-1:0]      pwdata,
    output logic [bda_pkg::APB_DATA_W-1:0]           prdata,
    output logic                                     pready
);

    localparam int SLOTS = bda_pkg::HOLIDAY_SLOTS;

    // ------------------------------------------------------------------
    // configuration register
    // ------------------------------------------------------------------
    logic [bda_pkg::HCOUNT_W-1:0] r_hcount;
    logic                         w_sel_hcount;

    assign pready       = 1'b1;
    assign w_sel_hcount = (paddr[bda_pkg::APB_ADDR_W-1:2] == bda_pkg::REG_HOLIDAY_COUNT);
    assign prdata       = w_sel_hcount
                        ? bda_pkg::APB_DATA_W'(r_hcount) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hcount <= '0;
        end else if (psel && penable && pwrite && pready && w_sel_hcount) begin
            r_hcount <= pwdata[bda_pkg::HCOUNT_W-1:0];
        end
    end

    // ------------------------------------------------------------------
    // state and captured transaction fields
    // ------------------------------------------------------------------
    bda_pkg::t_state                     r_state, n_state;
    logic                                r_func;
    logic [bda_pkg::SLOT_W-1:0]          r_slot;
    logic [bda_pkg::COUNT_W-1:0]         r_left, n_left;
    logic signed [bda_pkg::SERIAL_W-1:0] r_cand, n_cand;
    logic [bda_pkg::WD_W-1:0]            r_wd, n_wd;
    logic                                r_first, n_first;
    logic                                r_start_ok, n_start_ok;
    logic signed [bda_pkg::SERIAL_W-1:0] r_res, n_res;

    // output register
    logic                                r_ov;
    logic signed [bda_pkg::SERIAL_W-1:0] r_out_serial;
    logic                                r_out_biz;

    logic                                w_accept;
    logic                                w_load_we;
    logic                                w_flush;
    logic                                w_done;
    logic                                w_push;
    logic                                w_tail_biz;
    bda_pkg::t_conv_res                  w_conv;
    bda_pkg::t_probe                     w_link [SLOTS+1];
    bda_pkg::t_probe                     w_tail;

    assign i_req.ready = (r_state == bda_pkg::ST_IDLE);
    assign w_accept    = i_req.valid && i_req.ready;

    // ------------------------------------------------------------------
    // date converter, fed straight from the accepted transaction
    // ------------------------------------------------------------------
    bda_conv u_conv (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (w_accept),
        .i_year  (i_req.year),
        .i_month (i_req.month),
        .i_day   (i_req.day),
        .o_res   (w_conv)
    );

    // ------------------------------------------------------------------
    // holiday cell chain: each cell owns one slot, candidates shift through
    // ------------------------------------------------------------------
    always_comb begin
        w_link[0].valid   = (r_state == bda_pkg::ST_RUN);
        w_link[0].first   = r_first;
        w_link[0].weekend = (r_wd == bda_pkg::WD_SUN) || (r_wd == bda_pkg::WD_SAT);
        w_link[0].hit     = 1'b0;
        w_link[0].serial  = r_cand;
    end

    for (genvar g = 0; g < SLOTS; g++) begin : g_cell
        bda_cell u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_flush (w_flush),
            // slots at or above the configured count do not take part
            .i_en    (32'(r_hcount) > 32'(g)),
            .i_we    (w_load_we && (32'(r_slot) == 32'(g))),
            .i_wdata (w_conv.serial),
            .i_probe (w_link[g]),
            .o_probe (w_link[g+1])
        );
    end

    assign w_tail     = w_link[SLOTS];
    assign w_tail_biz = !w_tail.weekend && !w_tail.hit;

    // ------------------------------------------------------------------
    // sequencer
    // ------------------------------------------------------------------
    always_comb begin
        n_state    = r_state;
        n_left     = r_left;
        n_cand     = r_cand;
        n_wd       = r_wd;
        n_first    = r_first;
        n_start_ok = r_start_ok;
        n_res      = r_res;
        w_load_we  = 1'b0;
        w_flush    = 1'b0;
        w_done     = 1'b0;
        w_push     = 1'b0;

        case (r_state)
            bda_pkg::ST_IDLE: begin
                if (w_accept) begin
                    n_state = bda_pkg::ST_CONV;
                end
            end
            bda_pkg::ST_CONV: begin
                if (w_conv.valid) begin
                    if (r_func == bda_pkg::FUNC_LOAD) begin
                        // store the holiday, no response
                        w_load_we = 1'b1;
                        n_state   = bda_pkg::ST_IDLE;
                    end else begin
                        n_cand  = w_conv.serial;
                        n_wd    = w_conv.wd;
                        n_first = 1'b1;
                        n_state = bda_pkg::ST_RUN;
                    end
                end
            end
            bda_pkg::ST_RUN: begin
                // advance the candidate by one calendar day every cycle
                n_cand  = r_cand + 23'sd1;
                n_wd    = (r_wd == bda_pkg::WD_SAT) ? bda_pkg::WD_SUN : r_wd + 3'd1;
                n_first = 1'b0;
                if (w_tail.valid) begin
                    if (w_tail.first) begin
                        // start date: report its status, does not count
                        n_start_ok = w_tail_biz;
                        w_done     = (r_left == '0);
                    end else if (w_tail_biz) begin
                        n_left = r_left - 1'b1;
                        w_done = (r_left == bda_pkg::COUNT_W'(1));
                    end
                end
                if (w_done) begin
                    // drop the candidates still in the chain
                    n_res   = w_tail.serial;
                    w_flush = 1'b1;
                    n_state = bda_pkg::ST_PUSH;
                end
            end
            bda_pkg::ST_PUSH: begin
                if (!r_ov || o_rsp.ready) begin
                    w_push  = 1'b1;
                    n_state = bda_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = bda_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= bda_pkg::ST_IDLE;
            r_ov    <= 1'b0;
        end else begin
            r_state <= n_state;
            if (w_push) begin
                r_ov <= 1'b1;
            end else if (o_rsp.ready) begin
                r_ov <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_func <= i_req.func;
            r_slot <= i_req.slot;
            r_left <= i_req.count;
        end else begin
            r_left <= n_left;
        end
        r_cand     <= n_cand;
        r_wd       <= n_wd;
        r_first    <= n_first;
        r_start_ok <= n_start_ok;
        r_res      <= n_res;
        if (w_push) begin
            r_out_serial <= r_res;
            r_out_biz    <= r_start_ok;
        end
    end

    assign o_rsp.valid             = r_ov;
    assign o_rsp.result_serial     = r_out_serial;
    assign o_rsp.start_is_business = r_out_biz;

    // ------------------------------------------------------------------
    // assertions
    // ------------------------------------------------------------------
    a_probe_only_in_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_tail.valid |-> (r_state == bda_pkg::ST_RUN))
        else $error("probe left the cell chain outside the run state");

    a_rsp_from_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_rsp.valid) |-> ($past(r_state) == bda_pkg::ST_PUSH))
        else $error("response raised without a finished query");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bda_pkg::ST_RUN && w_tail.valid && !w_tail.first && w_tail_biz)
        |-> (r_left != '0))
        else $error("business day counted after the target was reached");

endmodule
`default_nettype wire

>>> tb/sv/bda_tb_pkg.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// bda_tb_pkg: scoreboard of the business day date adder bench
// Predicts each query result from its own date arithmetic and holiday table
// and checks arriving results in order.
// ----------------------------------------------------------------------------
package bda_tb_pkg;
    import bda_pkg::*;

    typedef struct {
        logic                func;
        logic [YEAR_W-1:0]   year;
        logic [MONTH_W-1:0]  month;
        logic [DAY_W-1:0]    day;
        logic [COUNT_W-1:0]  count;
        logic [SLOT_W-1:0]   slot;
    } date_item_t;

    typedef struct {
        logic signed [SERIAL_W-1:0] serial;
        logic                       start_business;
    } business_answer_t;

    class business_day_scoreboard;
        longint           holiday_serials [HOLIDAY_SLOTS];
        int unsigned      active_holidays;
        business_answer_t awaited_answers [$];
        int unsigned      failures;
        int unsigned      loads;
        int unsigned      queries;
        int unsigned      answers;

        function void set_holiday_count(logic [HCOUNT_W-1:0] value);
            active_holidays = (value > HOLIDAY_SLOTS) ? HOLIDAY_SLOTS : value;
        endfunction

        // days since 1970-01-01, March-based years in 400-year eras
        function longint civil_serial(logic [YEAR_W-1:0] yr, logic [MONTH_W-1:0] mo,
                                      logic [DAY_W-1:0] dy);
            longint y, m, d, era, yoe, doy, doe;
            y = (yr > YEAR_MAX) ? YEAR_MAX : yr;
            m = mo;
            d = dy;
            if (m <= 2) begin
                y = y - 1;
            end
            era = ((y >= 0) ? y : y - 399) / 400;
            yoe = y - era * 400;
            doy = (153 * ((m > 2) ? m - 3 : m + 9) + 2) / 5 + d - 1;
            doe = yoe * 365 + yoe / 4 - yoe / 100 + doy;
            return era * 146097 + doe - 719468;
        endfunction

        function bit is_business(longint s);
            longint wd;
            wd = ((s % 7) + 11) % 7;
            if (wd == WD_SUN || wd == WD_SAT) begin
                return 1'b0;
            end
            for (int i = 0; i < active_holidays; i++) begin
                if (holiday_serials[i] == s) begin
                    return 1'b0;
                end
            end
            return 1'b1;
        endfunction

        // Note an accepted transaction: store a holiday or queue the expected answer.
        function void note_item(date_item_t it);
            longint           s;
            int unsigned      remaining;
            business_answer_t answer;
            s = civil_serial(it.year, it.month, it.day);
            if (it.func == FUNC_LOAD) begin
                if (it.slot < HOLIDAY_SLOTS) begin
                    holiday_serials[it.slot] = s;
                end
                loads++;
                return;
            end
            queries++;
            answer.start_business = is_business(s);
            remaining = it.count;
            while (remaining > 0) begin
                s++;
                if (is_business(s)) begin
                    remaining--;
                end
            end
            answer.serial = s[SERIAL_W-1:0];
            awaited_answers.push_back(answer);
        endfunction

        function void check_answer(logic signed [SERIAL_W-1:0] serial, logic start_business);
            business_answer_t want;
            if (awaited_answers.size() == 0) begin
                $error("result with no query pending: result_serial %0d", serial);
                failures++;
                return;
            end
            want = awaited_answers.pop_front();
            answers++;
            if (serial !== want.serial) begin
                $error("result_serial: expected %0d, got %0d", want.serial, serial);
                failures++;
            end
            if (start_business !== want.start_business) begin
                $error("start_is_business: expected %0d, got %0d",
                       want.start_business, start_business);
                failures++;
            end
        endfunction
    endclass

endpackage

>>> tb/sv/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: bench of the business day date adder
// Drives holiday loads and business day queries through the request channel,
// sets the holiday count over APB between phases, and checks every result
// against the scoreboard's prediction under several pacing patterns.
// ----------------------------------------------------------------------------
module tb_top;
    import bda_pkg::*;
    import bda_tb_pkg::*;

    localparam int RESET_CYCLES    = 8;
    // a load produces nothing; let it settle before APB
    localparam int SETTLE_CYCLES   = 64;
    // the watchdog limit covers the longest query and the output hold-off
    localparam int WATCHDOG_LIMIT  = 20000;
    localparam int HOLD_OFF_CYCLES = 600;
    localparam int PHASE_ITEMS     = 70;
    localparam int PHASES          = 5;
    localparam logic [APB_ADDR_W-1:0] HCOUNT_ADDR = {REG_HOLIDAY_COUNT, 2'b00};

    logic                  i_clk;
    logic                  i_rst_n = 1'b0;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_ADDR_W-1:0] paddr;
    logic [APB_DATA_W-1:0] pwdata;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    int unsigned send_idle_pct  = 0;
    int unsigned recv_stall_pct = 0;
    bit          hold_off_req   = 1'b0;
    int unsigned idle_cycles    = 0;

    // holiday dates as sent, so queries can start right on one
    date_item_t slot_dates   [HOLIDAY_SLOTS];
    bit         slot_written [HOLIDAY_SLOTS];

    business_day_scoreboard sb = new;

    bda_req_if req ();
    bda_rsp_if rsp ();

    business_day_date_adder i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req),
        .o_rsp   (rsp),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        i_clk = 1'b0;
        #5;
        i_clk = 1'b1;
        #5;
    end

    // ------------------------------------------------------------------------
    // Monitors: sample at the rising edge, before the block's updates land
    // ------------------------------------------------------------------------
    always @(posedge i_clk) begin : req_monitor
        date_item_t seen;
        if (i_rst_n && req.valid && req.ready) begin
            seen.func  = req.func;
            seen.year  = req.year;
            seen.month = req.month;
            seen.day   = req.day;
            seen.count = req.count;
            seen.slot  = req.slot;
            sb.note_item(seen);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && rsp.valid && rsp.ready) begin
            sb.check_answer(rsp.result_serial, rsp.start_is_business);
        end
    end

    // Watchdog: count cycles with no transaction on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (req.valid && req.ready) || (rsp.valid && rsp.ready)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transaction for %0d cycles", idle_cycles);
            $display("end of test: mismatches");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    // ------------------------------------------------------------------------
    // Receiver: stall at random, or hold ready low for a long stretch on request
    // ------------------------------------------------------------------------
    initial begin
        rsp.ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_off_req) begin
                // hold off while the sender keeps offering, so the block backs up
                rsp.ready = 1'b0;
                repeat (HOLD_OFF_CYCLES - 1) @(negedge i_clk);
                hold_off_req = 1'b0;
            end else begin
                rsp.ready = ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // ------------------------------------------------------------------------
    // Item builders
    // ------------------------------------------------------------------------
    function automatic date_item_t make_item(logic func, int y, int m, int d, int c, int s);
        date_item_t it;
        it.func  = func;
        it.year  = YEAR_W'(y);
        it.month = MONTH_W'(m);
        it.day   = DAY_W'(d);
        it.count = COUNT_W'(c);
        it.slot  = SLOT_W'(s);
        return it;
    endfunction

    // mostly short advances; long ones are rare
    function automatic logic [COUNT_W-1:0] random_count();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 70) begin
            return COUNT_W'($urandom_range(20));
        end else if (r < 90) begin
            return COUNT_W'($urandom_range(300, 21));
        end
        return COUNT_W'($urandom_range(1023, 301));
    endfunction

    // a well-formed calendar date as a query, with random count and slot
    function automatic date_item_t valid_date(int lo, int hi);
        date_item_t  it;
        int unsigned y, m, last;
        y = $urandom_range(hi, lo);
        m = $urandom_range(12, 1);
        case (m)
            2: begin
                last = ((y % 4 == 0 && y % 100 != 0) || y % 400 == 0) ? 29 : 28;
            end
            4, 6, 9, 11: begin
                last = 30;
            end
            default: begin
                last = 31;
            end
        endcase
        it.func  = FUNC_QUERY;
        it.year  = YEAR_W'(y);
        it.month = MONTH_W'(m);
        it.day   = DAY_W'($urandom_range(last, 1));
        it.count = random_count();
        it.slot  = SLOT_W'($urandom_range(HOLIDAY_SLOTS - 1));
        return it;
    endfunction

    function automatic date_item_t random_item();
        date_item_t  it;
        int unsigned r, s;
        r = $urandom_range(99);
        if (r < 12) begin
            // holiday load, mostly in the years the queries crowd into
            it = ($urandom_range(99) < 80) ? valid_date(2023, 2026) : valid_date(1, 9999);
            it.func = FUNC_LOAD;
        end else if (r < 22) begin
            // noise: any field value, out-of-range months, days and years included
            it = make_item(FUNC_QUERY, $urandom_range(16383), $urandom_range(15),
                           $urandom_range(31), random_count(),
                           $urandom_range(HOLIDAY_SLOTS - 1));
        end else if (r < 30) begin
            // start right on a stored holiday where one is known
            s = $urandom_range(HOLIDAY_SLOTS - 1);
            if (slot_written[s]) begin
                it       = slot_dates[s];
                it.func  = FUNC_QUERY;
                it.count = random_count();
            end else begin
                it = valid_date(2023, 2026);
            end
        end else if (r < 65) begin
            it = valid_date(2023, 2026);
        end else begin
            it = valid_date(1, 9999);
        end
        return it;
    endfunction

    // ------------------------------------------------------------------------
    // Drivers: change inputs at the falling edge
    // ------------------------------------------------------------------------
    task automatic send_item(date_item_t it);
        while ($urandom_range(99) < send_idle_pct) begin
            req.valid = 1'b0;
            @(negedge i_clk);
        end
        req.valid = 1'b1;
        req.func  = it.func;
        req.year  = it.year;
        req.month = it.month;
        req.day   = it.day;
        req.count = it.count;
        req.slot  = it.slot;
        if (it.func == FUNC_LOAD) begin
            slot_dates[it.slot]   = it;
            slot_written[it.slot] = 1'b1;
        end
        do @(posedge i_clk); while (!req.ready);
        @(negedge i_clk);
    endtask

    // Drop valid, wait for every awaited result, then let a trailing load finish.
    task automatic drain();
        req.valid = 1'b0;
        while (sb.awaited_answers.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    // Write holiday_count, then read it back.
    task automatic program_holiday_count(logic [HCOUNT_W-1:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = HCOUNT_ADDR;
        pwdata  = APB_DATA_W'(value);
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        sb.set_holiday_count(value);
        @(negedge i_clk);
        penable = 1'b0;
        pwrite  = 1'b0;
        @(negedge i_clk);
        penable = 1'b1;
        do @(posedge i_clk); while (!pready);
        if (prdata[HCOUNT_W-1:0] !== value) begin
            $error("holiday_count readback: expected %0d, got %0d",
                   value, prdata[HCOUNT_W-1:0]);
            sb.failures++;
        end
        @(negedge i_clk);
        psel    = 1'b0;
        penable = 1'b0;
    endtask

    // Load every slot a query is about to compare against but nobody has written.
    task automatic fill_slots(int unsigned active);
        date_item_t it;
        for (int i = 0; i < active && i < HOLIDAY_SLOTS; i++) begin
            if (!slot_written[i]) begin
                it      = valid_date(2023, 2026);
                it.func = FUNC_LOAD;
                it.slot = SLOT_W'(i);
                send_item(it);
            end
        end
    endtask

    // ------------------------------------------------------------------------
    // Stimulus
    // ------------------------------------------------------------------------
    initial begin : stimulus
        logic [HCOUNT_W-1:0] hcount;
        req.valid = 1'b0;
        req.func  = FUNC_QUERY;
        req.year  = '0;
        req.month = '0;
        req.day   = '0;
        req.count = '0;
        req.slot  = '0;
        psel      = 1'b0;
        penable   = 1'b0;
        pwrite    = 1'b0;
        paddr     = '0;
        pwdata    = '0;

        repeat (RESET_CYCLES) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);
        program_holiday_count('0);

        // Directed: weekdays, weekends, field extremes, odd dates, no holidays yet
        send_item(make_item(FUNC_QUERY, 1970, 1, 1, 0, 0));        // epoch, a Thursday
        send_item(make_item(FUNC_QUERY, 2024, 6, 15, 0, 0));       // Saturday start
        send_item(make_item(FUNC_QUERY, 2024, 6, 16, 0, 0));       // Sunday start
        send_item(make_item(FUNC_QUERY, 2024, 6, 14, 1, 0));       // Friday, skip weekend
        send_item(make_item(FUNC_QUERY, 1, 1, 1, 0, 0));           // lowest valid year
        send_item(make_item(FUNC_QUERY, 9999, 12, 31, 1023, 0));   // top year, longest advance
        send_item(make_item(FUNC_QUERY, 16383, 12, 31, 3, 31));    // year saturates
        send_item(make_item(FUNC_QUERY, 0, 3, 1, 0, 0));           // year zero
        send_item(make_item(FUNC_QUERY, 0, 0, 0, 5, 0));           // month and day zero
        send_item(make_item(FUNC_QUERY, 2023, 15, 31, 2, 0));      // month far out of range
        send_item(make_item(FUNC_QUERY, 2023, 2, 31, 0, 0));       // day past month end
        send_item(make_item(FUNC_QUERY, 1969, 12, 31, 10, 0));     // negative serial
        send_item(make_item(FUNC_QUERY, 2024, 2, 29, 1023, 0));    // leap day, long advance
        // holidays, most around the year end, one on a Saturday, one repeated
        send_item(make_item(FUNC_LOAD, 2024, 12, 25, 0, 0));
        send_item(make_item(FUNC_LOAD, 2024, 12, 26, 0, 1));
        send_item(make_item(FUNC_LOAD, 2025, 1, 1, 0, 2));
        send_item(make_item(FUNC_LOAD, 2024, 12, 28, 0, 3));
        send_item(make_item(FUNC_LOAD, 2024, 12, 24, 0, 4));
        send_item(make_item(FUNC_LOAD, 2025, 1, 1, 0, 5));
        send_item(make_item(FUNC_LOAD, 2024, 7, 4, 0, 6));
        send_item(make_item(FUNC_LOAD, 2024, 11, 28, 0, 7));
        // top slot stays outside the active range for now
        send_item(make_item(FUNC_LOAD, 2025, 1, 2, 0, HOLIDAY_SLOTS - 1));
        drain();
        program_holiday_count(HCOUNT_W'(8));
        send_item(make_item(FUNC_QUERY, 2024, 12, 25, 0, 0));      // start on a holiday
        send_item(make_item(FUNC_QUERY, 2024, 12, 23, 5, 0));      // step across holidays
        send_item(make_item(FUNC_QUERY, 2024, 12, 31, 1, 0));      // next day is a holiday
        drain();

        // Random phases, each with its own holiday count and pacing
        for (int p = 0; p < PHASES; p++) begin
            case (p)
                0: begin
                    hcount = HCOUNT_W'(63);          // above the table, saturates
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
                1: begin
                    hcount = HCOUNT_W'(HOLIDAY_SLOTS);
                    send_idle_pct  = 65;
                    recv_stall_pct = 0;
                end
                2: begin
                    hcount = HCOUNT_W'($urandom_range(HOLIDAY_SLOTS - 1, 1));
                    send_idle_pct  = 0;
                    recv_stall_pct = 65;
                end
                3: begin
                    hcount = HCOUNT_W'($urandom_range(63));
                    send_idle_pct  = 21;
                    recv_stall_pct = 21;
                end
                default: begin
                    hcount = HCOUNT_W'(12);
                    send_idle_pct  = 0;
                    recv_stall_pct = 0;
                end
            endcase
            program_holiday_count(hcount);
            fill_slots(hcount);
            if (p == PHASES - 1) begin
                hold_off_req = 1'b1;
            end
            repeat (PHASE_ITEMS) send_item(random_item());
            drain();
        end

        if (sb.awaited_answers.size() != 0) begin
            $error("%0d expected results never arrived", sb.awaited_answers.size());
        end
        $display("covered %0d holiday loads and %0d queries, %0d results checked,",
                 sb.loads, sb.queries, sb.answers);
        $display("holiday counts 0 to 63, four pacing patterns and a long output hold-off");
        if (sb.failures == 0 && sb.awaited_answers.size() == 0) begin
            $display("end of test: clean");
        end else begin
            $display("end of test: mismatches");
        end
        $finish;
    end

endmodule
